// ----- hw/rtl/irb_pkg.sv -----
// ---------------------------------------------------------------------------
// irb_pkg - shared types and constants for the rotate/bilinear unit
// Fixed field widths, register indexes and the structs passed between blocks.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package irb_pkg;

	// Fixed widths of ports and internal mapping values
	localparam int DIM_BITS   = 9;   // source width/height register
	localparam int POS_BITS   = 9;   // pos_x / pos_y
	localparam int TRIG_BITS  = 16;  // cosine / sine, signed Q2.14
	localparam int ABS_BITS   = 15;  // magnitude of a saturated Q2.14 value
	localparam int EXT_BITS   = 11;  // rotated extent before the 10-bit report
	localparam int OFS_BITS   = 12;  // twice the offset from the output center
	localparam int NX_BITS    = 28;  // source position in 2^-15 pixel units
	localparam int FIELD_BITS = 16;  // channel ports
	localparam int SIZE_BITS  = 10;  // rotated_width / rotated_height ports
	localparam int Q14_BITS   = 14;
	localparam int ONE_Q14    = 16384;
	localparam int PRD_BITS   = 24;  // magnitude times dimension

	// Register indexes on the configuration port
	localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_COS_VALUE     = 2'd2;
	localparam logic [1:0] REG_SIN_VALUE     = 2'd3;

	// Input function codes
	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	// Configuration as seen by the datapath
	typedef struct packed {
		logic [DIM_BITS-1:0]  width;
		logic [DIM_BITS-1:0]  height;
		logic [TRIG_BITS-1:0] cos_v;
		logic [TRIG_BITS-1:0] sin_v;
	} cfg_t;

	// Mapped source neighborhood of one sample
	typedef struct packed {
		logic                in_src;
		logic [POS_BITS-1:0] x0;
		logic [POS_BITS-1:0] y0;
		logic [POS_BITS-1:0] x1;
		logic [POS_BITS-1:0] y1;
		logic [EXT_BITS-1:0] ow;
		logic [EXT_BITS-1:0] oh;
	} map_t;

	// Transaction carried alongside the mapping pipeline
	typedef struct packed {
		logic                     smp;
		logic                     wr;
		logic [POS_BITS-1:0]      x;
		logic [POS_BITS-1:0]      y;
		logic [4*FIELD_BITS-1:0]  data;
	} item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/image_rotate_bilinear_unit.sv -----
// ---------------------------------------------------------------------------
// image_rotate_bilinear_unit - frame rotation with bilinear sampling
// Frame store in four parity banks, mapping pipeline, four channel lanes and
// a merging output register.
// ---------------------------------------------------------------------------
// Usage:
//   Program source_width, source_height, cos_value and sin_value over the APB
//   port while no transaction is in flight. Send load transactions (func = 0)
//   to fill the frame store, then sample transactions (func = 1) with output
//   coordinates. Each sample returns one result transaction; a load returns
//   nothing. Both channels use valid/ready.
//   Throughput: one transaction per cycle unless the output stalls. The four
//   neighbors come from four banks split by row and column parity, one read
//   port each, so one sample per cycle reads the store with no conflict.
//   Reset: registers return to 256 x 256, cos 1.0, sin 0; the pipeline
//   empties. The frame store is not cleared; read only loaded pixels.
//   Stall: when the receiver holds ready low, the result register holds and
//   the stages behind it fill up one by one; in_ready drops only when every
//   stage is occupied.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module image_rotate_bilinear_unit #(
	parameter int MAX_WIDTH        = 256,
	parameter int MAX_HEIGHT       = 256,
	parameter int CHANNEL_BITS     = 16,
	parameter int WEIGHT_FRAC_BITS = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	// configuration port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input channel
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         func,
	input  wire  [8:0]  pos_x,
	input  wire  [8:0]  pos_y,
	input  wire  [15:0] in_red,
	input  wire  [15:0] in_green,
	input  wire  [15:0] in_blue,
	input  wire  [15:0] in_alpha,
	// output channel
	output logic        out_valid,
	input  wire         out_ready,
	output logic [15:0] out_red,
	output logic [15:0] out_green,
	output logic [15:0] out_blue,
	output logic [15:0] out_alpha,
	output logic        inside_source,
	output logic [9:0]  rotated_width,
	output logic [9:0]  rotated_height
);

	localparam int CB  = CHANNEL_BITS;
	localparam int WFB = WEIGHT_FRAC_BITS;
	localparam int DW  = 4 * CB;
	localparam int FB  = irb_pkg::FIELD_BITS;
	localparam int CW  = ($clog2(MAX_WIDTH) < 2) ? 2 : $clog2(MAX_WIDTH);
	localparam int RW  = ($clog2(MAX_HEIGHT) < 2) ? 2 : $clog2(MAX_HEIGHT);
	localparam int BA  = CW + RW - 2;
	localparam int BDEPTH = 1 << BA;

	// configuration registers
	logic [irb_pkg::DIM_BITS-1:0]  source_width_q, source_height_q;
	logic [irb_pkg::TRIG_BITS-1:0] cos_value_q, sin_value_q;
	irb_pkg::cfg_t                 cfg;
	logic                          cfg_wr;

	// pipeline control
	logic [10:1] adv;
	logic [9:1]  vld_q;
	irb_pkg::item_t item_s1, item_s2, item_s3, item_s4, item_s5, item_s6;
	logic           ld_ok;

	// mapping results
	irb_pkg::map_t       map_s6;
	logic [WFB-1:0]      tx_s6, ty_s6, tx_s7, ty_s7;

	// stage 7 to 9 metadata
	logic                          smp_s7, smp_s8, smp_s9;
	logic                          inside_s7, inside_s8, inside_s9;
	logic [irb_pkg::EXT_BITS-1:0]  ow_s7, ow_s8, ow_s9, oh_s7, oh_s8, oh_s9;
	logic                          x0p_s7, x1p_s7, y0p_s7, y1p_s7;

	// bank ports
	logic [DW-1:0] bank_rd [4];
	logic [DW-1:0] wr_data;
	logic [DW-1:0] p00, p10, p01, p11;
	logic [CB-1:0] lane_val [4];

	// output register
	logic          out_valid_q;
	logic [CB-1:0] red_q, green_q, blue_q, alpha_q;
	logic          inside_q;
	logic [9:0]    rw_q, rh_q;

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_width_q  <= irb_pkg::DIM_BITS'(256);
			source_height_q <= irb_pkg::DIM_BITS'(256);
			cos_value_q     <= irb_pkg::TRIG_BITS'(irb_pkg::ONE_Q14);
			sin_value_q     <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				irb_pkg::REG_SOURCE_WIDTH:  source_width_q  <= pwdata[8:0];
				irb_pkg::REG_SOURCE_HEIGHT: source_height_q <= pwdata[8:0];
				irb_pkg::REG_COS_VALUE:     cos_value_q     <= pwdata[15:0];
				irb_pkg::REG_SIN_VALUE:     sin_value_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (paddr[3:2])
			irb_pkg::REG_SOURCE_WIDTH:  prdata = 32'(source_width_q);
			irb_pkg::REG_SOURCE_HEIGHT: prdata = 32'(source_height_q);
			irb_pkg::REG_COS_VALUE:     prdata = 32'(cos_value_q);
			irb_pkg::REG_SIN_VALUE:     prdata = 32'(sin_value_q);
			default:                    prdata = '0;
		endcase
	end

	assign cfg.width  = source_width_q;
	assign cfg.height = source_height_q;
	assign cfg.cos_v  = cos_value_q;
	assign cfg.sin_v  = sin_value_q;

	// ------------------------------------------------------------------
	// Stage advance: a stage moves when empty or when the next one moves
	// ------------------------------------------------------------------
	always_comb begin
		adv[10] = !out_valid_q || out_ready;
		for (int k = 9; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign in_ready = adv[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= 9; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Drop loads that fall outside the store
	assign ld_ok = (13'(pos_x) < 13'(MAX_WIDTH)) && (13'(pos_y) < 13'(MAX_HEIGHT));

	// Carry the transaction alongside the mapping stages
	always_ff @(posedge clk) begin
		if (adv[1]) begin
			item_s1.smp  <= (func == irb_pkg::FUNC_SAMPLE);
			item_s1.wr   <= (func == irb_pkg::FUNC_LOAD) && ld_ok;
			item_s1.x    <= pos_x;
			item_s1.y    <= pos_y;
			item_s1.data <= {FB'(in_alpha[CB-1:0]), FB'(in_blue[CB-1:0]),
				FB'(in_green[CB-1:0]), FB'(in_red[CB-1:0])};
		end
		if (adv[2]) begin
			item_s2 <= item_s1;
		end
		if (adv[3]) begin
			item_s3 <= item_s2;
		end
		if (adv[4]) begin
			item_s4 <= item_s3;
		end
		if (adv[5]) begin
			item_s5 <= item_s4;
		end
		if (adv[6]) begin
			item_s6 <= item_s5;
		end
	end

	// ------------------------------------------------------------------
	// Coordinate mapping
	// ------------------------------------------------------------------
	irb_map #(
		.MAX_WIDTH        (MAX_WIDTH),
		.MAX_HEIGHT       (MAX_HEIGHT),
		.WEIGHT_FRAC_BITS (WFB)
	) u_map (
		.clk    (clk),
		.en     (adv[6:1]),
		.cfg    (cfg),
		.pos_x  (pos_x),
		.pos_y  (pos_y),
		.map_s6 (map_s6),
		.tx_s6  (tx_s6),
		.ty_s6  (ty_s6)
	);

	// ------------------------------------------------------------------
	// Frame store: four banks by row and column parity
	// ------------------------------------------------------------------
	for (genvar i = 0; i < DW / CB; i++) begin : g_wdata
		assign wr_data[i*CB +: CB] = item_s6.data[i*FB +: CB];
	end

	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic [1:0] BSEL = 2'(b);

		logic [DW-1:0]    mem [BDEPTH];
		logic [DW-1:0]    rd_s7;
		logic [8:0]       col9, row9, wcol9, wrow9;
		logic [CW+8:0]    col_x, wcol_x;
		logic [RW+8:0]    row_x, wrow_x;
		logic [BA-1:0]    raddr, waddr;
		logic             we;

		// Pick the neighbor of this bank's parity
		always_comb begin
			col9   = (map_s6.x0[0] == BSEL[0]) ? map_s6.x0 : map_s6.x1;
			row9   = (map_s6.y0[0] == BSEL[1]) ? map_s6.y0 : map_s6.y1;
			wcol9  = item_s6.x;
			wrow9  = item_s6.y;
			col_x  = {{CW{1'b0}}, col9};
			row_x  = {{RW{1'b0}}, row9};
			wcol_x = {{CW{1'b0}}, wcol9};
			wrow_x = {{RW{1'b0}}, wrow9};
			raddr  = {row_x[RW-1:1], col_x[CW-1:1]};
			waddr  = {wrow_x[RW-1:1], wcol_x[CW-1:1]};
			we     = vld_q[6] && item_s6.wr &&
				(wrow9[0] == BSEL[1]) && (wcol9[0] == BSEL[0]);
		end

		// Write loads and read samples in pipeline order
		always_ff @(posedge clk) begin
			if (adv[7]) begin
				if (we) begin
					mem[waddr] <= wr_data;
				end
				rd_s7 <= mem[raddr];
			end
		end

		assign bank_rd[b] = rd_s7;
	end

	// Hold the neighborhood description next to the read data
	always_ff @(posedge clk) begin
		if (adv[7]) begin
			smp_s7    <= item_s6.smp;
			inside_s7 <= map_s6.in_src;
			ow_s7     <= map_s6.ow;
			oh_s7     <= map_s6.oh;
			x0p_s7    <= map_s6.x0[0];
			x1p_s7    <= map_s6.x1[0];
			y0p_s7    <= map_s6.y0[0];
			y1p_s7    <= map_s6.y1[0];
			tx_s7     <= tx_s6;
			ty_s7     <= ty_s6;
		end
		if (adv[8]) begin
			smp_s8    <= smp_s7;
			inside_s8 <= inside_s7;
			ow_s8     <= ow_s7;
			oh_s8     <= oh_s7;
		end
		if (adv[9]) begin
			smp_s9    <= smp_s8;
			inside_s9 <= inside_s8;
			ow_s9     <= ow_s8;
			oh_s9     <= oh_s8;
		end
	end

	// Route bank data to the four corners
	always_comb begin
		p00 = bank_rd[{y0p_s7, x0p_s7}];
		p10 = bank_rd[{y0p_s7, x1p_s7}];
		p01 = bank_rd[{y1p_s7, x0p_s7}];
		p11 = bank_rd[{y1p_s7, x1p_s7}];
	end

	// ------------------------------------------------------------------
	// Channel lanes
	// ------------------------------------------------------------------
	for (genvar k = 0; k < 4; k++) begin : g_lane
		irb_lane #(
			.CHANNEL_BITS     (CB),
			.WEIGHT_FRAC_BITS (WFB)
		) u_lane (
			.clk   (clk),
			.en    (adv[9:8]),
			.p00   (p00[k*CB +: CB]),
			.p10   (p10[k*CB +: CB]),
			.p01   (p01[k*CB +: CB]),
			.p11   (p11[k*CB +: CB]),
			.tx    (tx_s7),
			.ty    (ty_s7),
			.value (lane_val[k])
		);
	end

	// ------------------------------------------------------------------
	// Merge lanes into the result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv[10]) begin
			out_valid_q <= vld_q[9] && smp_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			inside_q <= inside_s9;
			rw_q     <= ow_s9[9:0];
			rh_q     <= oh_s9[9:0];
			if (inside_s9) begin
				red_q   <= lane_val[0];
				green_q <= lane_val[1];
				blue_q  <= lane_val[2];
				alpha_q <= lane_val[3];
			end else begin
				red_q   <= '0;
				green_q <= '0;
				blue_q  <= '0;
				alpha_q <= {CB{1'b1}};
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign out_red        = FB'(red_q);
	assign out_green      = FB'(green_q);
	assign out_blue       = FB'(blue_q);
	assign out_alpha      = FB'(alpha_q);
	assign inside_source  = inside_q;
	assign rotated_width  = rw_q;
	assign rotated_height = rh_q;

endmodule

`default_nettype wire

// ----- hw/rtl/irb_map.sv -----
// ---------------------------------------------------------------------------
// irb_map - inverse rotation of an output coordinate to a source position
// Six stages: extent products, extents, center offsets, rotation products,
// rounding, and the neighborhood with bilinear weights and the inside test.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irb_map #(
	parameter int MAX_WIDTH        = 256,
	parameter int MAX_HEIGHT       = 256,
	parameter int WEIGHT_FRAC_BITS = 8
) (
	input  wire                                 clk,
	input  wire  [5:0]                          en,
	input  irb_pkg::cfg_t                       cfg,
	input  wire  [irb_pkg::POS_BITS-1:0]        pos_x,
	input  wire  [irb_pkg::POS_BITS-1:0]        pos_y,
	output irb_pkg::map_t                       map_s6,
	output logic [WEIGHT_FRAC_BITS-1:0]         tx_s6,
	output logic [WEIGHT_FRAC_BITS-1:0]         ty_s6
);

	localparam int WFB = WEIGHT_FRAC_BITS;
	localparam int PS  = 15 - WFB;
	localparam int NXB = irb_pkg::NX_BITS;
	localparam int PB  = irb_pkg::PRD_BITS;

	logic [irb_pkg::DIM_BITS-1:0]         w_eff, h_eff;
	logic signed [irb_pkg::TRIG_BITS-1:0] c_sat, s_sat;
	logic [irb_pkg::ABS_BITS-1:0]         ac, as_v;

	logic [irb_pkg::POS_BITS-1:0]  px_s1, py_s1, px_s2, py_s2;
	logic [PB-1:0]                 aw_s1, sh_s1, sw_s1, ch_s1;
	logic [irb_pkg::EXT_BITS-1:0]  ow_s2, oh_s2, ow_s3, oh_s3, ow_s4, oh_s4, ow_s5, oh_s5;
	logic signed [irb_pkg::OFS_BITS-1:0] ex_s3, ey_s3;
	logic signed [NXB-1:0]         cex_s4, sey_s4, sex_s4, cey_s4;
	logic signed [NXB-1:0]         sx_s5, sy_s5;

	logic [PB+1:0]                 wsum, hsum;
	logic [PB+1-irb_pkg::Q14_BITS:0] wq, hq;
	logic signed [NXB-1:0]         cx_ofs, cy_ofs, rnd, nx, ny, lim_x, lim_y;
	logic [irb_pkg::POS_BITS-1:0]  x0, y0;

	// Saturate dimensions and trig values
	always_comb begin
		w_eff = cfg.width;
		if (cfg.width == '0) begin
			w_eff = irb_pkg::DIM_BITS'(1);
		end else if (13'(cfg.width) > 13'(MAX_WIDTH)) begin
			w_eff = irb_pkg::DIM_BITS'(MAX_WIDTH);
		end
		h_eff = cfg.height;
		if (cfg.height == '0) begin
			h_eff = irb_pkg::DIM_BITS'(1);
		end else if (13'(cfg.height) > 13'(MAX_HEIGHT)) begin
			h_eff = irb_pkg::DIM_BITS'(MAX_HEIGHT);
		end
		c_sat = $signed(cfg.cos_v);
		if (c_sat > 16'sd16384) begin
			c_sat = 16'sd16384;
		end else if (c_sat < -16'sd16384) begin
			c_sat = -16'sd16384;
		end
		s_sat = $signed(cfg.sin_v);
		if (s_sat > 16'sd16384) begin
			s_sat = 16'sd16384;
		end else if (s_sat < -16'sd16384) begin
			s_sat = -16'sd16384;
		end
		ac   = irb_pkg::ABS_BITS'(c_sat < 0 ? -c_sat : c_sat);
		as_v = irb_pkg::ABS_BITS'(s_sat < 0 ? -s_sat : s_sat);
	end

	// Rotated extents, rounded up, at least one
	always_comb begin
		wsum = (PB+2)'(aw_s1) + (PB+2)'(sh_s1) + (PB+2)'(irb_pkg::ONE_Q14 - 1);
		hsum = (PB+2)'(sw_s1) + (PB+2)'(ch_s1) + (PB+2)'(irb_pkg::ONE_Q14 - 1);
		wq   = wsum[PB+1:irb_pkg::Q14_BITS];
		hq   = hsum[PB+1:irb_pkg::Q14_BITS];
	end

	// Source position sums with the source center and half-LSB rounding
	always_comb begin
		cx_ofs = $signed(NXB'({(w_eff - 9'd1), 14'd0}));
		cy_ofs = $signed(NXB'({(h_eff - 9'd1), 14'd0}));
		rnd    = $signed(NXB'(1) << (PS - 1));
		nx     = cex_s4 + sey_s4 + cx_ofs + rnd;
		ny     = cey_s4 - sex_s4 + cy_ofs + rnd;
		lim_x  = $signed(NXB'({(w_eff - 9'd1), {WFB{1'b0}}}));
		lim_y  = $signed(NXB'({(h_eff - 9'd1), {WFB{1'b0}}}));
		x0     = sx_s5[WFB +: irb_pkg::POS_BITS];
		y0     = sy_s5[WFB +: irb_pkg::POS_BITS];
	end

	// Advance the mapping stages
	always_ff @(posedge clk) begin
		if (en[0]) begin
			px_s1 <= pos_x;
			py_s1 <= pos_y;
			aw_s1 <= PB'(ac) * PB'(w_eff);
			sh_s1 <= PB'(as_v) * PB'(h_eff);
			sw_s1 <= PB'(as_v) * PB'(w_eff);
			ch_s1 <= PB'(ac) * PB'(h_eff);
		end
		if (en[1]) begin
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			ow_s2 <= (wq == '0) ? irb_pkg::EXT_BITS'(1) : irb_pkg::EXT_BITS'(wq);
			oh_s2 <= (hq == '0) ? irb_pkg::EXT_BITS'(1) : irb_pkg::EXT_BITS'(hq);
		end
		if (en[2]) begin
			ex_s3 <= $signed({2'b00, px_s2, 1'b0}) - $signed({1'b0, ow_s2}) + 12'sd1;
			ey_s3 <= $signed({2'b00, py_s2, 1'b0}) - $signed({1'b0, oh_s2}) + 12'sd1;
			ow_s3 <= ow_s2;
			oh_s3 <= oh_s2;
		end
		if (en[3]) begin
			cex_s4 <= NXB'(c_sat) * NXB'(ex_s3);
			sey_s4 <= NXB'(s_sat) * NXB'(ey_s3);
			sex_s4 <= NXB'(s_sat) * NXB'(ex_s3);
			cey_s4 <= NXB'(c_sat) * NXB'(ey_s3);
			ow_s4  <= ow_s3;
			oh_s4  <= oh_s3;
		end
		if (en[4]) begin
			sx_s5 <= nx >>> PS;
			sy_s5 <= ny >>> PS;
			ow_s5 <= ow_s4;
			oh_s5 <= oh_s4;
		end
		if (en[5]) begin
			map_s6.in_src <= (sx_s5 >= 0) && (sy_s5 >= 0) &&
				(sx_s5 <= lim_x) && (sy_s5 <= lim_y);
			map_s6.x0 <= x0;
			map_s6.y0 <= y0;
			map_s6.x1 <= (x0 == w_eff - 9'd1) ? x0 : x0 + 9'd1;
			map_s6.y1 <= (y0 == h_eff - 9'd1) ? y0 : y0 + 9'd1;
			map_s6.ow <= ow_s5;
			map_s6.oh <= oh_s5;
			tx_s6     <= sx_s5[WFB-1:0];
			ty_s6     <= sy_s5[WFB-1:0];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/irb_lane.sv -----
// ---------------------------------------------------------------------------
// irb_lane - bilinear blend of one color channel
// Horizontal blend of both rows, then the vertical blend, then rounding.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irb_lane #(
	parameter int CHANNEL_BITS     = 16,
	parameter int WEIGHT_FRAC_BITS = 8
) (
	input  wire                          clk,
	input  wire  [1:0]                   en,
	input  wire  [CHANNEL_BITS-1:0]      p00,
	input  wire  [CHANNEL_BITS-1:0]      p10,
	input  wire  [CHANNEL_BITS-1:0]      p01,
	input  wire  [CHANNEL_BITS-1:0]      p11,
	input  wire  [WEIGHT_FRAC_BITS-1:0]  tx,
	input  wire  [WEIGHT_FRAC_BITS-1:0]  ty,
	output logic [CHANNEL_BITS-1:0]      value
);

	localparam int CB = CHANNEL_BITS;
	localparam int WFB = WEIGHT_FRAC_BITS;
	localparam int AW = CB + WFB;
	localparam int VW = CB + 2 * WFB;

	logic [WFB:0]   wx0, wy0;
	logic [AW-1:0]  a_s8, b_s8;
	logic [WFB-1:0] ty_s8;
	logic [VW-1:0]  v_s9;
	logic [VW:0]    rounded;

	// Complementary weights
	always_comb begin
		wx0     = (WFB+1)'(1 << WFB) - (WFB+1)'(tx);
		wy0     = (WFB+1)'(1 << WFB) - (WFB+1)'(ty_s8);
		rounded = (VW+1)'(v_s9) + (VW+1)'(1 << (2 * WFB - 1));
		value   = rounded[2*WFB +: CB];
	end

	// Blend across, then down
	always_ff @(posedge clk) begin
		if (en[0]) begin
			a_s8  <= AW'(p00) * AW'(wx0) + AW'(p10) * AW'(tx);
			b_s8  <= AW'(p01) * AW'(wx0) + AW'(p11) * AW'(tx);
			ty_s8 <= ty;
		end
		if (en[1]) begin
			v_s9 <= VW'(a_s8) * VW'(wy0) + VW'(b_s8) * VW'(ty_s8);
		end
	end

endmodule

`default_nettype wire
